@@ sv/cpu8_arith_register_unit_core_assert.svh @@
// Assertion macros for the arithmetic register unit core
`ifndef CPU8_ARITH_REGISTER_UNIT_CORE_ASSERT_SVH
`define CPU8_ARITH_REGISTER_UNIT_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent
`define CAU_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: check failed");

// Consequent must hold in the cycle after the antecedent
`define CAU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: check failed");

`endif

@@ sv/cau_pkg.sv @@
// Types and constants shared by the arithmetic register unit
package cau_pkg;

    localparam logic [3:0] OP_ADD = 4'd0;
    localparam logic [3:0] OP_ADI = 4'd1;
    localparam logic [3:0] OP_INR = 4'd2;
    localparam logic [3:0] OP_SUB = 4'd3;
    localparam logic [3:0] OP_SUI = 4'd4;
    localparam logic [3:0] OP_DCR = 4'd5;
    localparam logic [3:0] OP_INX = 4'd6;
    localparam logic [3:0] OP_DCX = 4'd7;
    localparam logic [3:0] OP_DAD = 4'd8;
    localparam logic [3:0] OP_CMP = 4'd9;

    localparam logic [2:0] REG_A = 3'd0;
    localparam logic [2:0] REG_B = 3'd1;
    localparam logic [2:0] REG_C = 3'd2;
    localparam logic [2:0] REG_D = 3'd3;
    localparam logic [2:0] REG_E = 3'd4;
    localparam logic [2:0] REG_H = 3'd5;
    localparam logic [2:0] REG_L = 3'd6;

    localparam logic [1:0] PAIR_BC  = 2'd0;
    localparam logic [1:0] PAIR_DE  = 2'd1;
    localparam logic [1:0] PAIR_HL  = 2'd2;
    localparam logic [1:0] PAIR_BAD = 2'd3;

    // bit positions in the flag register
    localparam int FB_CARRY  = 0;
    localparam int FB_PARITY = 1;
    localparam int FB_ZERO   = 2;
    localparam int FB_SIGN   = 3;

    typedef struct packed {
        logic [3:0] req_type;
        logic [2:0] reg_sel;
        logic [1:0] pair_sel;
        logic [7:0] immediate;
    } t_req;

    typedef struct packed {
        logic [15:0] value;
        logic        flag_sign;
        logic        flag_zero;
        logic        flag_parity;
        logic        flag_carry;
        logic        invalid_pair;
    } t_res;

endpackage

@@ sv/cau_stream_if.sv @@
// Valid/ready channels carrying instruction and result items
interface cau_req_if
    import cau_pkg::*;
();
    logic valid;
    logic ready;
    t_req data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface cau_res_if
    import cau_pkg::*;
();
    logic valid;
    logic ready;
    t_res data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ sv/cpu8_arith_register_unit_core.sv @@
// Arithmetic register unit: register file, flags and single-pass execute stage
// An accepted item passes the input register, then the result register. Throughput: one item
// per cycle unless the output stalls; the execute logic between the two registers updates the
// register file and flags in the same edge that loads the result, so the next item sees them.
// Reset (synchronous, active low) clears registers A to L, the flags and both valid bits.
`include "cpu8_arith_register_unit_core_assert.svh"

module cpu8_arith_register_unit_core
    import cau_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    cau_req_if.sink    i_req,
    cau_res_if.source  o_res
);

    logic        r_in_valid;
    t_req        r_in;
    logic        r_out_valid;
    t_res        r_out;

    logic [7:0]  r_a, r_b, r_c, r_d, r_e, r_h, r_l;
    logic [7:0]  n_a, n_b, n_c, n_d, n_e, n_h, n_l;
    logic [3:0]  r_flags;
    logic [3:0]  n_flags;
    logic [15:0] n_value;
    logic        n_bad;

    logic        ex_fire;
    logic [7:0]  reg_rd;
    logic        is_imm;
    logic        is_sub;
    logic [7:0]  alu_b;
    logic [8:0]  alu9;
    logic [7:0]  step8;
    logic [15:0] pair_rd;
    logic [15:0] hl_rd;
    logic [16:0] pair17;

    function automatic logic [3:0] set_szp(input logic [3:0] f, input logic [7:0] v);
        logic [3:0] g;
        g            = f;
        g[FB_SIGN]   = v[7];
        g[FB_ZERO]   = (v == 8'h00);
        g[FB_PARITY] = ~^v;
        return g;
    endfunction

    assign ex_fire     = r_in_valid && (!r_out_valid || o_res.ready);
    assign i_req.ready = !r_in_valid || ex_fire;
    assign o_res.valid = r_out_valid;
    assign o_res.data  = r_out;

    // operand reads; select seven reads as zero
    always_comb begin
        unique case (r_in.reg_sel)
            REG_A:   reg_rd = r_a;
            REG_B:   reg_rd = r_b;
            REG_C:   reg_rd = r_c;
            REG_D:   reg_rd = r_d;
            REG_E:   reg_rd = r_e;
            REG_H:   reg_rd = r_h;
            REG_L:   reg_rd = r_l;
            default: reg_rd = 8'h00;
        endcase
    end

    always_comb begin
        unique case (r_in.pair_sel)
            PAIR_BC: pair_rd = {r_b, r_c};
            PAIR_DE: pair_rd = {r_d, r_e};
            PAIR_HL: pair_rd = {r_h, r_l};
            default: pair_rd = 16'h0000;
        endcase
    end

    assign hl_rd  = {r_h, r_l};
    assign is_imm = (r_in.req_type == OP_ADI) || (r_in.req_type == OP_SUI);
    assign is_sub = (r_in.req_type == OP_SUB) || (r_in.req_type == OP_SUI);
    assign alu_b  = is_imm ? r_in.immediate : reg_rd;
    // bit 8 of the difference is the borrow, i.e. A below the operand
    assign alu9   = is_sub ? ({1'b0, r_a} - {1'b0, alu_b}) : ({1'b0, r_a} + {1'b0, alu_b});
    assign step8  = (r_in.req_type == OP_INR) ? (reg_rd + 8'd1) : (reg_rd - 8'd1);

    always_comb begin
        unique case (r_in.req_type)
            OP_INX:  pair17 = {1'b0, pair_rd} + 17'd1;
            OP_DCX:  pair17 = {(pair_rd == 16'h0000), pair_rd - 16'd1};
            default: pair17 = {1'b0, hl_rd} + {1'b0, pair_rd};
        endcase
    end

    always_comb begin
        n_a     = r_a;
        n_b     = r_b;
        n_c     = r_c;
        n_d     = r_d;
        n_e     = r_e;
        n_h     = r_h;
        n_l     = r_l;
        n_flags = r_flags;
        n_value = 16'h0000;
        n_bad   = 1'b0;
        unique case (r_in.req_type)
            OP_ADD, OP_ADI, OP_SUB, OP_SUI: begin
                n_a              = alu9[7:0];
                n_flags          = set_szp(r_flags, alu9[7:0]);
                n_flags[FB_CARRY] = alu9[8];
                n_value          = {8'h00, alu9[7:0]};
            end
            OP_INR, OP_DCR: begin
                unique case (r_in.reg_sel)
                    REG_A:   n_a = step8;
                    REG_B:   n_b = step8;
                    REG_C:   n_c = step8;
                    REG_D:   n_d = step8;
                    REG_E:   n_e = step8;
                    REG_H:   n_h = step8;
                    REG_L:   n_l = step8;
                    default: ; // drop the write
                endcase
                n_flags = set_szp(r_flags, step8);
                n_value = {8'h00, step8};
            end
            OP_INX, OP_DCX, OP_DAD: begin
                if (r_in.pair_sel == PAIR_BAD) begin
                    n_bad = 1'b1;
                end else begin
                    n_flags[FB_CARRY] = pair17[16];
                    n_flags[FB_ZERO]  = (pair17[15:0] == 16'h0000);
                    n_value           = pair17[15:0];
                    if (r_in.req_type == OP_DAD) begin
                        {n_h, n_l} = pair17[15:0];
                    end else begin
                        unique case (r_in.pair_sel)
                            PAIR_BC: {n_b, n_c} = pair17[15:0];
                            PAIR_DE: {n_d, n_e} = pair17[15:0];
                            default: {n_h, n_l} = pair17[15:0];
                        endcase
                    end
                end
            end
            OP_CMP: begin
                n_flags[FB_CARRY] = (r_a < reg_rd);
                n_flags[FB_ZERO]  = (r_a == reg_rd);
            end
            default: ; // unused codes change nothing
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_req.ready) begin
            r_in_valid <= i_req.valid;
        end
        if (i_req.ready && i_req.valid) begin
            r_in <= i_req.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a     <= 8'h00;
            r_b     <= 8'h00;
            r_c     <= 8'h00;
            r_d     <= 8'h00;
            r_e     <= 8'h00;
            r_h     <= 8'h00;
            r_l     <= 8'h00;
            r_flags <= 4'h0;
        end else if (ex_fire) begin
            r_a     <= n_a;
            r_b     <= n_b;
            r_c     <= n_c;
            r_d     <= n_d;
            r_e     <= n_e;
            r_h     <= n_h;
            r_l     <= n_l;
            r_flags <= n_flags;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ex_fire) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
        if (ex_fire) begin
            r_out.value        <= n_value;
            r_out.flag_sign    <= n_flags[FB_SIGN];
            r_out.flag_zero    <= n_flags[FB_ZERO];
            r_out.flag_parity  <= n_flags[FB_PARITY];
            r_out.flag_carry   <= n_flags[FB_CARRY];
            r_out.invalid_pair <= n_bad;
        end
    end

    `CAU_ASSERT_NEXT(a_fire_gives_result, i_clk, i_rst_n, ex_fire, r_out_valid)
    `CAU_ASSERT_NEXT(a_in_held_on_stall, i_clk, i_rst_n, r_in_valid && !ex_fire, r_in_valid && $stable(r_in))
    `CAU_ASSERT_NEXT(a_bad_pair_no_change, i_clk, i_rst_n, ex_fire && n_bad, $stable({r_a, r_b, r_c, r_d, r_e, r_h, r_l, r_flags}))
    `CAU_ASSERT_NEXT(a_step_keeps_carry, i_clk, i_rst_n, ex_fire && ((r_in.req_type == OP_INR) || (r_in.req_type == OP_DCR)), $stable(r_flags[FB_CARRY]))

endmodule
